// File: rtl/core/vtep_pkg.sv
// ----------------------------------------------------------------------------
// vtep_pkg
// Shared constants, result codes and controller/datapath interface types of
// the terminal escape parser with UTF-8 front end.
// ----------------------------------------------------------------------------
`default_nettype none

package vtep_pkg;

    // Sizing
    localparam int MAX_PARAMS = 32;
    localparam int MAX_INTER  = 8;
    localparam int PIDX_W     = $clog2(MAX_PARAMS);
    localparam int PCNT_W     = 6;
    localparam int ICNT_W     = 4;
    localparam int PWORD_W    = 16;

    // Limits and special characters
    localparam logic [23:0] PAYLOAD_CAP = 24'd10485760;
    localparam logic [14:0] PARAM_MAX   = 15'd16384;
    localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CH_ESC      = 21'h1B;
    localparam logic [20:0] CH_CAN      = 21'h18;
    localparam logic [20:0] CH_SUB      = 21'h1A;
    localparam logic [20:0] CH_BEL      = 21'h07;
    localparam logic [20:0] CH_ST       = 21'h9C;
    localparam logic [20:0] CH_DEL      = 21'h7F;

    // Result actions
    localparam logic [3:0] ACT_PRINT    = 4'd0;
    localparam logic [3:0] ACT_EXECUTE  = 4'd1;
    localparam logic [3:0] ACT_ESC_DISP = 4'd2;
    localparam logic [3:0] ACT_CSI_HDR  = 4'd3;
    localparam logic [3:0] ACT_CSI_PAR  = 4'd4;
    localparam logic [3:0] ACT_OSC_BYTE = 4'd5;
    localparam logic [3:0] ACT_DCS_BYTE = 4'd6;
    localparam logic [3:0] ACT_APC_BYTE = 4'd7;
    localparam logic [3:0] ACT_OSC_END  = 4'd8;
    localparam logic [3:0] ACT_DCS_END  = 4'd9;
    localparam logic [3:0] ACT_APC_END  = 4'd10;

    // One result item
    typedef struct packed {
        logic [3:0]        action;
        logic [20:0]       code_point;
        logic [6:0]        final_byte;
        logic [63:0]       inter_bytes;
        logic [ICNT_W-1:0] inter_count;
        logic [PCNT_W-1:0] param_count;
        logic [14:0]       param_value;
        logic              param_is_sub;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic proc;
        logic sel_b;
        logic res_to_pend;
        logic res_to_out;
        logic pend_to_out;
        logic out_last;
        logic par_start;
        logic par_adv;
        logic in_par;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic dec_has_a;
        logic cpb_vld;
        logic res_vld;
        logic disp_par;
        logic pend_vld;
        logic out_free;
        logic data_ok;
        logic idx_last;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/vtep_ram.sv
// ----------------------------------------------------------------------------
// vtep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vtep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/vtep_ctrl.sv
// ----------------------------------------------------------------------------
// vtep_ctrl
// Sequencer: accepts one byte, runs up to two codepoints through the
// datapath, streams CSI parameters and orders result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module vtep_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire vtep_pkg::sts_t sts,
    output vtep_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PROC_A = 5'b00010,
        S_PROC_B = 5'b00100,
        S_PARAM  = 5'b01000,
        S_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   r_b, d_b;

    assign s_tready = (state_reg == S_IDLE);
    assign r_b      = sts.cpb_vld & sts.res_vld;
    assign d_b      = sts.cpb_vld & sts.disp_par;

    // Decode next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.dec_has_a ? S_PROC_A : S_PROC_B;
                end
            end
            S_PROC_A: begin
                cmd.proc        = 1'b1;
                cmd.res_to_pend = sts.res_vld;
                state_next      = S_PROC_B;
            end
            S_PROC_B: begin
                cmd.sel_b = 1'b1;
                if (d_b) begin
                    if (!sts.pend_vld || sts.out_free) begin
                        cmd.proc        = 1'b1;
                        cmd.pend_to_out = sts.pend_vld;
                        cmd.res_to_pend = 1'b1;
                        cmd.par_start   = 1'b1;
                        state_next      = S_PARAM;
                    end
                end else if (sts.pend_vld) begin
                    if (sts.out_free) begin
                        cmd.proc        = sts.cpb_vld;
                        cmd.pend_to_out = 1'b1;
                        cmd.out_last    = !r_b;
                        cmd.res_to_pend = r_b;
                        state_next      = r_b ? S_FLUSH : S_IDLE;
                    end
                end else if (r_b) begin
                    if (sts.out_free) begin
                        cmd.proc       = 1'b1;
                        cmd.res_to_out = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.proc   = sts.cpb_vld;
                    state_next = S_IDLE;
                end
            end
            S_PARAM: begin
                cmd.in_par = 1'b1;
                if (sts.data_ok && sts.out_free) begin
                    cmd.pend_to_out = 1'b1;
                    cmd.par_adv     = 1'b1;
                    if (sts.idx_last) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.pend_to_out = 1'b1;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/vtep_dp.sv
// ----------------------------------------------------------------------------
// vtep_dp
// Datapath: UTF-8 decoder, escape parser state, parameter store, pending
// result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtep_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [7:0]     in_byte,
    input  wire vtep_pkg::cmd_t cmd,
    input  wire logic           out_ready,
    output vtep_pkg::sts_t      sts,
    output vtep_pkg::res_t      out_res,
    output logic                out_vld,
    output logic                out_last
);

    typedef enum logic [9:0] {
        M_GROUND    = 10'b0000000001,
        M_ESC       = 10'b0000000010,
        M_ESC_INT   = 10'b0000000100,
        M_CSI_ENTRY = 10'b0000001000,
        M_CSI_PARAM = 10'b0000010000,
        M_CSI_INT   = 10'b0000100000,
        M_OSC       = 10'b0001000000,
        M_DCS       = 10'b0010000000,
        M_APC       = 10'b0100000000,
        M_IGNORE    = 10'b1000000000
    } mode_t;

    // UTF-8 decoder state
    logic [1:0]  u_pend_reg, u_pend_next;
    logic [2:0]  u_len_reg, u_len_next;
    logic [20:0] u_acc_reg, u_acc_next;
    logic [20:0] cpa_reg, cpa_next, cpb_reg, cpb_next;
    logic        cpb_vld_reg, cpb_vld_next;
    logic        has_a;

    // Parser state
    mode_t                        mode_reg, mode_next;
    logic [63:0]                  inter_reg, inter_next;
    logic [vtep_pkg::ICNT_W-1:0]  ifill_reg, ifill_next;
    logic [vtep_pkg::PCNT_W-1:0]  pfill_reg, pfill_next;
    logic [14:0]                  cur_reg, cur_next;
    logic                         pres_reg, pres_next;
    logic                         sub_reg, sub_next;
    logic [23:0]                  pcnt_reg, pcnt_next;

    // Result staging
    vtep_pkg::res_t               pend_reg, out_reg, res, par_res;
    logic                         pend_vld_reg, out_vld_reg, out_last_reg;
    logic                         res_vld, disp_par;
    logic [vtep_pkg::PIDX_W-1:0]  idx_reg, rd_addr;
    logic                         data_ok_reg;
    logic [vtep_pkg::PWORD_W-1:0] rd_data, wr_data;
    logic [vtep_pkg::PIDX_W-1:0]  wr_addr;
    logic                         wr_en;
    logic                         out_free;

    // Process-step locals
    logic [20:0] ch;
    logic        is_str, run_param, do_add, do_push, push_sub, do_esc, do_csi;
    logic        do_end, do_exec, do_print, do_pay;
    logic [14:0] push_val;
    logic [17:0] prod;
    logic [2:0]  need;
    logic [24:0] pay_sum;
    logic [3:0]  pay_act, end_act;

    // Decode the incoming byte into up to two codepoints
    always_comb begin
        logic [20:0] acc;
        logic        ok;
        logic        fresh;
        acc          = {u_acc_reg[14:0], in_byte[5:0]};
        ok           = 1'b1;
        fresh        = 1'b1;
        u_pend_next  = u_pend_reg;
        u_len_next   = u_len_reg;
        u_acc_next   = u_acc_reg;
        cpa_next     = vtep_pkg::CP_REPLACE;
        cpb_next     = vtep_pkg::CP_REPLACE;
        cpb_vld_next = 1'b0;
        has_a        = 1'b0;
        if (u_pend_reg != 2'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                fresh       = 1'b0;
                u_acc_next  = acc;
                u_pend_next = u_pend_reg - 2'd1;
                if (acc < 21'h80) begin
                    ok = 1'b0;
                end else if (acc < 21'h800 && u_len_reg >= 3'd3) begin
                    ok = 1'b0;
                end else if (acc < 21'h10000 && u_len_reg >= 3'd4) begin
                    ok = 1'b0;
                end else if (acc >= 21'hD800 && acc <= 21'hDFFF) begin
                    ok = 1'b0;
                end else if (acc > vtep_pkg::CP_MAX) begin
                    ok = 1'b0;
                end
                if (u_pend_reg == 2'd1) begin
                    cpb_vld_next = 1'b1;
                    cpb_next     = ok ? acc : vtep_pkg::CP_REPLACE;
                end
            end else begin
                u_pend_next = 2'd0;
                has_a       = 1'b1;
            end
        end
        if (fresh) begin
            if (!in_byte[7]) begin
                cpb_vld_next = 1'b1;
                cpb_next     = {13'd0, in_byte};
            end else if (in_byte[7:5] == 3'b110) begin
                u_acc_next  = {16'd0, in_byte[4:0]};
                u_pend_next = 2'd1;
                u_len_next  = 3'd2;
            end else if (in_byte[7:4] == 4'b1110) begin
                u_acc_next  = {17'd0, in_byte[3:0]};
                u_pend_next = 2'd2;
                u_len_next  = 3'd3;
            end else if (in_byte[7:3] == 5'b11110) begin
                u_acc_next  = {18'd0, in_byte[2:0]};
                u_pend_next = 2'd3;
                u_len_next  = 3'd4;
            end else begin
                cpb_vld_next = 1'b1;
            end
        end
    end

    // Run one codepoint through the escape state machine
    always_comb begin
        ch         = cmd.sel_b ? cpb_reg : cpa_reg;
        is_str     = (mode_reg == M_OSC) || (mode_reg == M_DCS) || (mode_reg == M_APC);
        mode_next  = mode_reg;
        inter_next = inter_reg;
        ifill_next = ifill_reg;
        pfill_next = pfill_reg;
        cur_next   = cur_reg;
        pres_next  = pres_reg;
        sub_next   = sub_reg;
        pcnt_next  = pcnt_reg;
        run_param  = 1'b0;
        do_add     = 1'b0;
        do_push    = 1'b0;
        push_val   = '0;
        push_sub   = 1'b0;
        do_esc     = 1'b0;
        do_csi     = 1'b0;
        do_end     = 1'b0;
        do_exec    = 1'b0;
        do_print   = 1'b0;
        do_pay     = 1'b0;
        prod       = '0;
        wr_en      = 1'b0;
        wr_addr    = pfill_reg[vtep_pkg::PIDX_W-1:0];
        wr_data    = '0;
        res        = '0;
        res_vld    = 1'b0;
        disp_par   = 1'b0;

        unique case (mode_reg)
            M_OSC:   begin end_act = vtep_pkg::ACT_OSC_END; pay_act = vtep_pkg::ACT_OSC_BYTE; end
            M_DCS:   begin end_act = vtep_pkg::ACT_DCS_END; pay_act = vtep_pkg::ACT_DCS_BYTE; end
            default: begin end_act = vtep_pkg::ACT_APC_END; pay_act = vtep_pkg::ACT_APC_BYTE; end
        endcase

        if (ch < 21'h80) begin
            need = 3'd1;
        end else if (ch < 21'h800) begin
            need = 3'd2;
        end else if (ch < 21'h10000) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
        pay_sum = {1'b0, pcnt_reg} + 25'(need);

        if (ch == vtep_pkg::CH_ESC) begin
            do_end     = is_str;
            mode_next  = M_ESC;
            inter_next = '0;
            ifill_next = '0;
        end else if (ch == vtep_pkg::CH_CAN || ch == vtep_pkg::CH_SUB) begin
            do_end    = is_str;
            mode_next = M_GROUND;
        end else begin
            unique case (mode_reg)
                M_GROUND: begin
                    if (ch < 21'h20) begin
                        do_exec = 1'b1;
                    end else if (ch != vtep_pkg::CH_DEL) begin
                        do_print = 1'b1;
                    end
                end
                M_ESC: begin
                    if (ch == 21'h5B) begin
                        pfill_next = '0;
                        cur_next   = '0;
                        pres_next  = 1'b0;
                        sub_next   = 1'b0;
                        inter_next = '0;
                        ifill_next = '0;
                        mode_next  = M_CSI_ENTRY;
                    end else if (ch == 21'h5D) begin
                        pcnt_next = '0;
                        mode_next = M_OSC;
                    end else if (ch >= 21'h20 && ch <= 21'h2F) begin
                        inter_next = '0;
                        ifill_next = '0;
                        do_add     = 1'b1;
                        mode_next  = M_ESC_INT;
                    end else if (ch == 21'h50) begin
                        pcnt_next = '0;
                        mode_next = M_DCS;
                    end else if (ch == 21'h5F) begin
                        pcnt_next = '0;
                        mode_next = M_APC;
                    end else if (ch == 21'h58 || ch == 21'h5E) begin
                        mode_next = M_IGNORE;
                    end else if (ch >= 21'h30 && ch <= 21'h7E) begin
                        do_esc = 1'b1;
                    end else if (ch < 21'h20) begin
                        do_exec = 1'b1;
                    end
                end
                M_ESC_INT: begin
                    if (ch >= 21'h20 && ch <= 21'h2F) begin
                        do_add = 1'b1;
                    end else if (ch >= 21'h30 && ch <= 21'h7E) begin
                        do_esc = 1'b1;
                    end else begin
                        mode_next = M_GROUND;
                    end
                end
                M_CSI_ENTRY: begin
                    pfill_next = '0;
                    cur_next   = '0;
                    pres_next  = 1'b0;
                    sub_next   = 1'b0;
                    inter_next = '0;
                    ifill_next = '0;
                    mode_next  = M_CSI_PARAM;
                    if (ch >= 21'h3C && ch <= 21'h3F) begin
                        do_add = 1'b1;
                    end else begin
                        run_param = 1'b1;
                    end
                end
                M_CSI_PARAM: begin
                    run_param = 1'b1;
                end
                M_CSI_INT: begin
                    if (ch >= 21'h20 && ch <= 21'h2F) begin
                        do_add = 1'b1;
                    end else if (ch >= 21'h40 && ch <= 21'h7E) begin
                        do_csi = 1'b1;
                    end else begin
                        mode_next = M_GROUND;
                    end
                end
                M_OSC, M_DCS, M_APC: begin
                    if (ch == vtep_pkg::CH_BEL || ch == vtep_pkg::CH_ST) begin
                        do_end    = 1'b1;
                        mode_next = M_GROUND;
                    end else begin
                        do_pay = 1'b1;
                    end
                end
                M_IGNORE: begin
                    if (ch == vtep_pkg::CH_BEL || ch == vtep_pkg::CH_ST) begin
                        mode_next = M_GROUND;
                    end
                end
                default: begin
                    mode_next = M_GROUND;
                end
            endcase
        end

        // Parameter characters
        if (run_param) begin
            if (ch >= 21'h30 && ch <= 21'h39) begin
                prod      = {cur_next, 3'b000} + {2'b00, cur_next, 1'b0} + 18'(ch[3:0]);
                cur_next  = (prod > 18'(vtep_pkg::PARAM_MAX)) ? vtep_pkg::PARAM_MAX
                                                             : prod[14:0];
                pres_next = 1'b1;
            end else if (ch == 21'h3B || ch == 21'h3A) begin
                do_push   = 1'b1;
                push_val  = pres_next ? cur_next : 15'd0;
                push_sub  = sub_next;
                cur_next  = '0;
                pres_next = 1'b0;
                sub_next  = (ch == 21'h3A);
            end else if (ch >= 21'h20 && ch <= 21'h2F) begin
                if (pres_next) begin
                    do_push   = 1'b1;
                    push_val  = cur_next;
                    push_sub  = sub_next;
                    cur_next  = '0;
                    pres_next = 1'b0;
                    sub_next  = 1'b0;
                end
                do_add    = 1'b1;
                mode_next = M_CSI_INT;
            end else if (ch >= 21'h40 && ch <= 21'h7E) begin
                do_push   = pres_next;
                push_val  = cur_next;
                push_sub  = sub_next;
                cur_next  = '0;
                pres_next = 1'b0;
                sub_next  = 1'b0;
                do_csi    = 1'b1;
            end else if (ch < 21'h20) begin
                do_exec = 1'b1;
            end else begin
                mode_next = M_GROUND;
            end
        end

        // Store a parameter, drop it when full
        if (do_push && pfill_next < vtep_pkg::PCNT_W'(vtep_pkg::MAX_PARAMS)) begin
            wr_en      = cmd.proc;
            wr_addr    = pfill_next[vtep_pkg::PIDX_W-1:0];
            wr_data    = {push_sub, push_val};
            pfill_next = pfill_next + 1'b1;
        end

        // Store an intermediate, drop it when full
        if (do_add && ifill_next < vtep_pkg::ICNT_W'(vtep_pkg::MAX_INTER)) begin
            inter_next[{ifill_next[2:0], 3'b000} +: 8] = ch[7:0];
            ifill_next = ifill_next + 1'b1;
        end

        // Form the result
        if (do_end) begin
            res.action = end_act;
            res_vld    = 1'b1;
            pcnt_next  = '0;
        end else if (do_exec) begin
            res.action     = vtep_pkg::ACT_EXECUTE;
            res.code_point = ch;
            res_vld        = 1'b1;
        end else if (do_print) begin
            res.action     = vtep_pkg::ACT_PRINT;
            res.code_point = ch;
            res_vld        = 1'b1;
        end else if (do_esc) begin
            res.action      = vtep_pkg::ACT_ESC_DISP;
            res.final_byte  = ch[6:0];
            res.inter_bytes = inter_next;
            res.inter_count = ifill_next;
            res_vld         = 1'b1;
            mode_next       = M_GROUND;
        end else if (do_csi) begin
            res.action      = vtep_pkg::ACT_CSI_HDR;
            res.final_byte  = ch[6:0];
            res.inter_bytes = inter_next;
            res.inter_count = ifill_next;
            res.param_count = pfill_next;
            res_vld         = 1'b1;
            disp_par        = (pfill_next != '0);
            mode_next       = M_GROUND;
        end else if (do_pay && pay_sum <= {1'b0, vtep_pkg::PAYLOAD_CAP}) begin
            res.action     = pay_act;
            res.code_point = ch;
            res_vld        = 1'b1;
            pcnt_next      = pay_sum[23:0];
        end
    end

    // Form a parameter result from the store read data
    always_comb begin
        par_res              = '0;
        par_res.action       = vtep_pkg::ACT_CSI_PAR;
        par_res.param_value  = rd_data[14:0];
        par_res.param_is_sub = rd_data[15];
    end

    vtep_ram #(
        .WIDTH (vtep_pkg::PWORD_W),
        .DEPTH (vtep_pkg::MAX_PARAMS)
    ) u_param_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read the next parameter as soon as the current one moves on
    assign rd_addr  = cmd.par_adv ? idx_reg + 1'b1 : idx_reg;
    assign out_free = !out_vld_reg || out_ready;

    assign sts.dec_has_a = has_a;
    assign sts.cpb_vld   = cpb_vld_reg;
    assign sts.res_vld   = res_vld;
    assign sts.disp_par  = disp_par;
    assign sts.pend_vld  = pend_vld_reg;
    assign sts.out_free  = out_free;
    assign sts.data_ok   = data_ok_reg;
    assign sts.idx_last  = ({1'b0, idx_reg} == pfill_reg - 1'b1);

    assign out_res  = out_reg;
    assign out_vld  = out_vld_reg;
    assign out_last = out_last_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_pend_reg   <= '0;
            u_len_reg    <= '0;
            u_acc_reg    <= '0;
            cpb_vld_reg  <= 1'b0;
            mode_reg     <= M_GROUND;
            inter_reg    <= '0;
            ifill_reg    <= '0;
            pfill_reg    <= '0;
            cur_reg      <= '0;
            pres_reg     <= 1'b0;
            sub_reg      <= 1'b0;
            pcnt_reg     <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            data_ok_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (cmd.accept) begin
                u_pend_reg  <= u_pend_next;
                u_len_reg   <= u_len_next;
                u_acc_reg   <= u_acc_next;
                cpb_vld_reg <= cpb_vld_next;
            end
            if (cmd.proc) begin
                mode_reg  <= mode_next;
                inter_reg <= inter_next;
                ifill_reg <= ifill_next;
                pfill_reg <= pfill_next;
                cur_reg   <= cur_next;
                pres_reg  <= pres_next;
                sub_reg   <= sub_next;
                pcnt_reg  <= pcnt_next;
            end
            if (cmd.res_to_pend || cmd.par_adv) begin
                pend_vld_reg <= 1'b1;
            end else if (cmd.pend_to_out) begin
                pend_vld_reg <= 1'b0;
            end
            if (cmd.pend_to_out || cmd.res_to_out) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
            data_ok_reg <= cmd.in_par;
            if (cmd.par_start) begin
                idx_reg <= '0;
            end else if (cmd.par_adv) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cpa_reg <= cpa_next;
            cpb_reg <= cpb_next;
        end
        if (cmd.par_adv) begin
            pend_reg <= par_res;
        end else if (cmd.res_to_pend) begin
            pend_reg <= res;
        end
        if (cmd.pend_to_out) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.out_last;
        end else if (cmd.res_to_out) begin
            out_reg      <= res;
            out_last_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/vt_escape_utf8_parser.sv
// ----------------------------------------------------------------------------
// vt_escape_utf8_parser
// Terminal byte stream parser: UTF-8 decode feeding a VT500-style escape
// state machine, with streamed CSI parameters and string payloads.
// ----------------------------------------------------------------------------
// Usage:
//  The s_ channel takes one raw byte per transaction. The m_ channel returns
//  zero or more results per byte; m_tlast marks the last result of a byte.
//  A byte that yields nothing produces no transaction.
//  Bytes are taken one at a time: a new byte is accepted only once all
//  results of the last one have reached m_. A replacement codepoint for a
//  broken UTF-8 sequence is run before the byte itself. A CSI dispatch
//  with parameters gives the header, a read of the parameter store (a RAM
//  with a registered read port), then one parameter result per cycle while
//  m_tready does not stall. Each result passes through the output register,
//  some by way of the pending register first, before it appears on m_.
//  Reset (aresetn low, synchronous) returns the parser to ground with empty
//  UTF-8, intermediate and parameter state; no result is pending.
//  A stalled m_tready holds the current result and the sequencer, so s_tready
//  stays low until the last result of the byte in flight has reached m_.
// ----------------------------------------------------------------------------
`default_nettype none

module vt_escape_utf8_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,   // [20:0] code_point, [27:21] final_byte,
                                         // [91:28] intermediate_bytes,
                                         // [95:92] intermediate_count,
                                         // [101:96] param_count,
                                         // [116:102] param_value,
                                         // [117] param_is_sub, [119:118] zero
    output logic [3:0]        m_tuser,   // [3:0] action
    output logic              m_tlast    // last_of_run
);

    vtep_pkg::cmd_t cmd;
    vtep_pkg::sts_t sts;
    vtep_pkg::res_t out_res;

    vtep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vtep_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .out_ready (m_tready),
        .sts       (sts),
        .out_res   (out_res),
        .out_vld   (m_tvalid),
        .out_last  (m_tlast)
    );

    // Pack the result fields
    assign m_tuser = out_res.action;
    assign m_tdata = {2'b00, out_res.param_is_sub, out_res.param_value,
                      out_res.param_count, out_res.inter_count,
                      out_res.inter_bytes, out_res.final_byte,
                      out_res.code_point};

    // One byte in flight: acceptance always leaves the idle state
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("byte accepted while another is in flight");

    // Only defined actions leave the block
    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= vtep_pkg::ACT_APC_END)
        else $error("undefined action code");

    // Parameter values stay clamped
    a_param_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == vtep_pkg::ACT_CSI_PAR
            |-> m_tdata[116:102] <= vtep_pkg::PARAM_MAX)
        else $error("parameter above clamp");

endmodule

`default_nettype wire
